// File: rtl/core/tbple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbple_pkg: shared types and constants of the three-bit pulse encoder
// Sequencer states, register indexes, byte constants and idle clamping.
// ----------------------------------------------------------------------------
package tbple_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_BITS,
    S_FLUSH,
    S_FINAL
  } state_t;

  // Configuration register indexes
  localparam logic REG_INTRA = 1'b0;
  localparam logic REG_INTER = 1'b1;

  // Register reset values
  localparam logic [3:0] INTRA_RESET = 4'd1;
  localparam logic [3:0] INTER_RESET = 4'd2;

  // Line positions of one UART frame: start bit plus eight data bits, stop at 10
  localparam logic [3:0] POS_LIMIT   = 4'd10;
  localparam logic [7:0] BYTE_EMPTY  = 8'hFF;
  localparam logic [7:0] START_LOW   = 8'hFE;

  // Idle count saturates to 1..8 so every pulse fits in one frame
  function automatic logic [3:0] clamp_idle(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// File: rtl/core/tbple_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbple channel interfaces
// Valid/ready channels for input longs and for encoded frame bytes.
// ----------------------------------------------------------------------------
interface tbple_in_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] long_value;
  logic                 flush;

  modport source (output valid, output long_value, output flush, input ready);
  modport sink   (input valid, input long_value, input flush, output ready);
endinterface

interface tbple_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte_out;
  logic       last_of_run;

  modport source (output valid, output frame_byte_out, output last_of_run, input ready);
  modport sink   (input valid, input frame_byte_out, input last_of_run, output ready);
endinterface

// File: rtl/core/three_bit_pulse_long_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_bit_pulse_long_encoder_top: serial pulse encoder for words
// Encodes each input word LSB first as low pulses packed into UART bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one word per handshake, long_value plus a flush flag.
//   result : encoded frame bytes; last_of_run marks the final byte of a word.
//   cfg    : cfg_we/cfg_index/cfg_data write the intra (0) and inter (1)
//            idle counts; write only while the encoder is idle.
// Timing:
//   One bit of the word is placed per cycle by a shift register unless the
//   output stalls, then the flush state and the release of the held byte
//   follow; item.ready is high only in idle, so a new word is taken only
//   once the previous one has been released.
//   Each produced byte is held back one slot so its last flag is known.
// Stalls:
//   When the output register holds a byte, result.ready is low and a byte
//   must move to the output register, the sequencer pauses; nothing is dropped.
// Reset:
//   rst clears the sequencer, empties the frame under construction and sets
//   the idle counts to 1 (intra) and 2 (inter).
// ----------------------------------------------------------------------------
module three_bit_pulse_long_encoder_top #(
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [3:0] cfg_data,
  tbple_in_if.sink   item,
  tbple_out_if.source result
);

  localparam int CntW = $clog2(WORD_BITS);
  localparam logic [CntW-1:0] LastBit = CntW'(WORD_BITS - 1);

  tbple_pkg::state_t state, state_next;

  logic [WORD_BITS-1:0] shreg, shreg_next;
  logic [CntW-1:0]      cnt, cnt_next;
  logic                 flush_r, flush_r_next;
  logic [3:0]           bit_pos, bit_pos_next;
  logic [7:0]           pend, pend_next;
  logic                 h_valid, h_valid_next;
  logic [7:0]           h_byte, h_byte_next;
  logic                 o_valid, o_valid_next;
  logic [7:0]           o_byte, o_byte_next;
  logic                 o_last, o_last_next;
  logic [3:0]           intra, inter;

  // Bit placement signals
  logic       cur_bit, last_bit;
  logic [3:0] idle;
  logic [1:0] plen;
  logic       emit_a, emit_b, emit, fits;
  logic [3:0] bp1;
  logic [4:0] need;
  logic [7:0] pmask;
  logic [3:0] place_bp;
  logic [7:0] place_pend;
  logic       flush_emit;
  logic       o_free, go;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      intra <= tbple_pkg::INTRA_RESET;
      inter <= tbple_pkg::INTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbple_pkg::REG_INTRA: intra <= cfg_data;
        tbple_pkg::REG_INTER: inter <= cfg_data;
        default: ;
      endcase
    end
  end

  // Place the current bit into the frame under construction
  always_comb begin
    cur_bit  = shreg[0];
    last_bit = (cnt == LastBit);
    idle     = last_bit ? tbple_pkg::clamp_idle(inter) : tbple_pkg::clamp_idle(intra);
    plen     = cur_bit ? 2'd1 : 2'd2;
    emit_a   = (bit_pos >= tbple_pkg::POS_LIMIT);
    bp1      = emit_a ? 4'd0 : bit_pos;
    need     = {1'b0, bp1} + 5'(plen) + 5'(idle);
    fits     = (bp1 != 4'd0) && (need <= 5'(tbple_pkg::POS_LIMIT));
    emit_b   = (bp1 != 4'd0) && !fits;
    emit     = emit_a || emit_b;
    pmask    = (cur_bit ? 8'h01 : 8'h03) << 3'(bp1 - 4'd1);
    if (fits) begin
      place_bp   = need[3:0];
      place_pend = pend & ~pmask;
    end else begin
      // fresh frame: the start bit is the pulse
      place_bp   = 4'(plen) + idle;
      place_pend = cur_bit ? tbple_pkg::BYTE_EMPTY : tbple_pkg::START_LOW;
    end
  end

  // Progress condition per state
  always_comb begin
    o_free     = !o_valid || result.ready;
    flush_emit = flush_r && (bit_pos != 4'd0);
    unique case (state)
      tbple_pkg::S_BITS:  go = !(emit && h_valid) || o_free;
      tbple_pkg::S_FLUSH: go = !(flush_emit && h_valid) || o_free;
      tbple_pkg::S_FINAL: go = !h_valid || o_free;
      default:            go = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tbple_pkg::S_IDLE:  if (item.valid) state_next = tbple_pkg::S_BITS;
      tbple_pkg::S_BITS:  if (go && last_bit) state_next = tbple_pkg::S_FLUSH;
      tbple_pkg::S_FLUSH: if (go) state_next = tbple_pkg::S_FINAL;
      tbple_pkg::S_FINAL: if (go) state_next = tbple_pkg::S_IDLE;
      default:            state_next = tbple_pkg::S_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    shreg_next   = shreg;
    cnt_next     = cnt;
    flush_r_next = flush_r;
    bit_pos_next = bit_pos;
    pend_next    = pend;
    h_valid_next = h_valid;
    h_byte_next  = h_byte;
    o_valid_next = o_valid && !result.ready;
    o_byte_next  = o_byte;
    o_last_next  = o_last;
    unique case (state)
      tbple_pkg::S_IDLE: begin
        if (item.valid) begin
          shreg_next   = item.long_value;
          flush_r_next = item.flush;
          cnt_next     = '0;
        end
      end
      tbple_pkg::S_BITS: begin
        if (go) begin
          shreg_next   = shreg >> 1;
          cnt_next     = cnt + CntW'(1);
          bit_pos_next = place_bp;
          pend_next    = place_pend;
          if (emit) begin
            // older held byte goes out, new one waits for its last flag
            if (h_valid) begin
              o_valid_next = 1'b1;
              o_byte_next  = h_byte;
              o_last_next  = 1'b0;
            end
            h_valid_next = 1'b1;
            h_byte_next  = pend;
          end
        end
      end
      tbple_pkg::S_FLUSH: begin
        if (go && flush_emit) begin
          if (h_valid) begin
            o_valid_next = 1'b1;
            o_byte_next  = h_byte;
            o_last_next  = 1'b0;
          end
          h_valid_next = 1'b1;
          h_byte_next  = pend;
          bit_pos_next = 4'd0;
          pend_next    = tbple_pkg::BYTE_EMPTY;
        end
      end
      tbple_pkg::S_FINAL: begin
        if (go && h_valid) begin
          o_valid_next = 1'b1;
          o_byte_next  = h_byte;
          o_last_next  = 1'b1;
          h_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tbple_pkg::S_IDLE;
      bit_pos <= 4'd0;
      pend    <= tbple_pkg::BYTE_EMPTY;
      h_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      bit_pos <= bit_pos_next;
      pend    <= pend_next;
      h_valid <= h_valid_next;
      o_valid <= o_valid_next;
    end
    shreg   <= shreg_next;
    cnt     <= cnt_next;
    flush_r <= flush_r_next;
    h_byte  <= h_byte_next;
    o_byte  <= o_byte_next;
    o_last  <= o_last_next;
  end

  // Port drive
  assign item.ready            = (state == tbple_pkg::S_IDLE);
  assign result.valid          = o_valid;
  assign result.frame_byte_out = o_byte;
  assign result.last_of_run    = o_last;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    bit_pos <= tbple_pkg::POS_LIMIT)
    else $error("line position beyond frame end");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    state == tbple_pkg::S_IDLE |-> !h_valid)
    else $error("held byte left over between words");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    bit_pos == 4'd0 |-> pend == tbple_pkg::BYTE_EMPTY)
    else $error("empty frame carries pulses");

  a_last_from_final: assert property (@(posedge clk) disable iff (rst)
    !o_valid ##1 (o_valid && o_last) |-> $past(state) == tbple_pkg::S_FINAL)
    else $error("last flag set outside final release");

endmodule

// File: tb/tb_three_bit_pulse_long_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_bit_pulse_long_encoder_top: self-checking bench of the pulse encoder
// Feeds 32-bit longs with flush flags through the valid/ready input channel,
// predicts the UART bytes each long turns into and checks every byte that
// leaves the output channel, in order, data and last flag alike. A short
// table of corner cases comes first, then random longs under random idle
// counts. Both channels idle at random; the output holds off once for a long
// stretch so that the encoder backs up into its input.
// ----------------------------------------------------------------------------
module tb_three_bit_pulse_long_encoder_top;

  localparam int WORD_BITS       = 32;
  localparam int SETTLE_CYCLES   = WORD_BITS + 8;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER      = 40;
  localparam int RANDOM_PHASES   = 5;
  localparam int LONGS_PER_PHASE = 22;
  localparam int N_DIRECTED      = 21;

  // one output word as the checker sees it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_t;

  // one stimulus row; typed rows carry count-1 body bytes then a tail byte
  typedef struct packed {
    logic [3:0]  intra;
    logic [3:0]  inter;
    logic [31:0] value;
    logic        flush;
    logic        typed;
    logic [7:0]  body;
    int          count;
    logic [7:0]  tail;
  } long_vec_t;

  long_vec_t directed [N_DIRECTED] = '{
    // reset idle counts: 3 zeros or 5 ones per byte
    '{4'd1, 4'd2, 32'h0000_0000, 1'b1, 1'b1, 8'h92, 11, 8'hF2},
    '{4'd1, 4'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h55, 7,  8'hFD},
    '{4'd1, 4'd2, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 0,  8'h00},
    '{4'd1, 4'd2, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 0,  8'h00},
    '{4'd1, 4'd2, 32'h8000_0001, 1'b1, 1'b0, 8'h00, 0,  8'h00},
    '{4'd1, 4'd2, 32'h7FFF_FFFE, 1'b0, 1'b0, 8'h00, 0,  8'h00},
    '{4'd1, 4'd2, 32'hAAAA_AAAA, 1'b0, 1'b0, 8'h00, 0,  8'h00},
    '{4'd1, 4'd2, 32'h5555_5555, 1'b1, 1'b0, 8'h00, 0,  8'h00},
    // zero intra acts as 1, 15 inter saturates to 8
    '{4'd0, 4'd15, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 0, 8'h00},
    '{4'd0, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 0, 8'h00},
    '{4'd0, 4'd15, 32'h0F0F_0F0F, 1'b1, 1'b0, 8'h00, 0, 8'h00},
    '{4'd0, 4'd15, 32'hDEAD_BEEF, 1'b0, 1'b0, 8'h00, 0, 8'h00},
    '{4'd0, 4'd15, 32'h1234_5678, 1'b1, 1'b0, 8'h00, 0, 8'h00},
    // widest idle: one pulse per byte, up to 33 bytes from one long
    '{4'd8, 4'd1, 32'h0000_0000, 1'b1, 1'b1, 8'hFE, 32, 8'hFE},
    '{4'd8, 4'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 32, 8'hFF},
    '{4'd8, 4'd1, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 0,  8'h00},
    '{4'd8, 4'd1, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 0,  8'h00},
    '{4'd8, 4'd1, 32'hCCCC_CCCC, 1'b1, 1'b0, 8'h00, 0,  8'h00},
    // 15 intra saturates, zero inter acts as 1
    '{4'd15, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 32, 8'hFF},
    '{4'd15, 4'd0, 32'h3333_3333, 1'b0, 1'b0, 8'h00, 0,  8'h00},
    '{4'd15, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 0,  8'h00}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [3:0] cfg_data;

  tbple_in_if #(.WORD_BITS(WORD_BITS)) item_ch ();
  tbple_out_if                         result_ch ();

  three_bit_pulse_long_encoder_top #(.WORD_BITS(WORD_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // encoder mirror: line position, byte under construction, raw idle counts
  logic [3:0] line_pos;
  logic [7:0] byte_acc;
  logic [3:0] intra_reg;
  logic [3:0] inter_reg;
  logic [7:0] step_bytes[$];
  frame_t     bytes_due[$];

  int mismatches  = 0;
  int bytes_taken = 0;
  int quiet_cycles = 0;
  int burst_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] sat_idle(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

  // ship the byte under construction unless it is empty
  task automatic close_byte();
    if (line_pos != 4'd0) begin
      step_bytes = {step_bytes, byte_acc};
      line_pos = 4'd0;
      byte_acc = tbple_pkg::BYTE_EMPTY;
    end
  endtask

  // a one is a single low period, a zero two; idle periods follow
  task automatic place_pulse(input logic one, input logic [3:0] idle);
    logic [4:0] need;
    logic       fresh;
    fresh = 1'b1;
    if (line_pos >= tbple_pkg::POS_LIMIT) close_byte();
    if (line_pos != 4'd0) begin
      need = {1'b0, line_pos} + (one ? 5'd1 : 5'd2) + {1'b0, idle};
      if (need > {1'b0, tbple_pkg::POS_LIMIT}) begin
        close_byte();
      end else begin
        byte_acc = byte_acc & ~((one ? 8'h01 : 8'h03) << (line_pos - 4'd1));
        line_pos = need[3:0];
        fresh = 1'b0;
      end
    end
    // fresh byte: the start bit is the pulse, a zero runs into data bit 0
    if (fresh) begin
      if (!one) begin
        byte_acc = byte_acc & tbple_pkg::START_LOW;
        line_pos = 4'd2 + idle;
      end else begin
        line_pos = 4'd1 + idle;
      end
    end
  endtask

  task automatic encode_long(input logic [31:0] value, input logic flush);
    step_bytes.delete();
    for (int i = 0; i < WORD_BITS; i++)
      place_pulse(value[i], (i == WORD_BITS - 1) ? sat_idle(inter_reg) : sat_idle(intra_reg));
    if (flush) close_byte();
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s: got %02h, want %02h (byte %0d)", field, got, want, bytes_taken);
    mismatches++;
  endtask

  // drive one long in bursts with random gaps, queue its bytes, wait for accept
  task automatic send_long(input long_vec_t v);
    int     gap;
    frame_t f;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    encode_long(v.value, v.flush);
    if (v.typed) begin
      for (int k = 0; k < v.count; k++) begin
        f.last = (k == v.count - 1);
        f.data = f.last ? v.tail : v.body;
        bytes_due = {bytes_due, f};
      end
    end else begin
      foreach (step_bytes[k]) begin
        f.data = step_bytes[k];
        f.last = (k == step_bytes.size() - 1);
        bytes_due = {bytes_due, f};
      end
    end
    item_ch.valid      <= 1'b1;
    item_ch.long_value <= v.value;
    item_ch.flush      <= v.flush;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // drain the encoder, then write both idle counts
  task automatic set_idle(input logic [3:0] intra, input logic [3:0] inter);
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tbple_pkg::REG_INTRA;
    cfg_data  <= intra;
    @(posedge clk);
    cfg_index <= tbple_pkg::REG_INTER;
    cfg_data  <= inter;
    @(posedge clk);
    cfg_we    <= 1'b0;
    intra_reg = intra;
    inter_reg = inter;
  endtask

  // stimulus
  initial begin
    long_vec_t v;
    item_ch.valid      <= 1'b0;
    item_ch.long_value <= '0;
    item_ch.flush      <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= tbple_pkg::REG_INTRA;
    cfg_data           <= 4'd0;
    line_pos  = 4'd0;
    byte_acc  = tbple_pkg::BYTE_EMPTY;
    intra_reg = tbple_pkg::INTRA_RESET;
    inter_reg = tbple_pkg::INTER_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[r]) begin
      if (directed[r].intra != intra_reg || directed[r].inter != inter_reg)
        set_idle(directed[r].intra, directed[r].inter);
      send_long(directed[r]);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idle(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      for (int n = 0; n < LONGS_PER_PHASE; n++) begin
        v = '0;
        case ($urandom_range(0, 9))
          0:       v.value = 32'h0000_0000;
          1:       v.value = 32'hFFFF_FFFF;
          2:       v.value = 32'h1 << $urandom_range(0, 31);
          3:       v.value = ~(32'h1 << $urandom_range(0, 31));
          4:       v.value = $urandom() & $urandom();
          5:       v.value = $urandom() | $urandom();
          default: v.value = $urandom();
        endcase
        v.flush = ($urandom_range(0, 2) == 0);
        send_long(v);
      end
    end

    item_ch.valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // output side: stall patterns in segments, one long hold-off mid run
  initial begin
    int seg;
    int mode;
    int period;
    bit held;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && bytes_taken >= HOLD_AFTER) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg    = $urandom_range(8, 64);
      mode   = $urandom_range(0, 3);
      period = $urandom_range(2, 6);
      for (int j = 0; j < seg; j++) begin
        case (mode)
          0, 1:    result_ch.ready <= 1'b1;
          2:       result_ch.ready <= ((j % period) == 0);
          default: result_ch.ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  // compare each accepted byte with the oldest one due
  always @(posedge clk) begin
    frame_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      bytes_taken++;
      if (bytes_due.size() == 0) begin
        report_mismatch("byte with nothing due", result_ch.frame_byte_out, 8'h00);
      end else begin
        want = bytes_due.pop_front();
        if (result_ch.frame_byte_out !== want.data)
          report_mismatch("frame_byte_out", result_ch.frame_byte_out, want.data);
        if (result_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", {7'd0, result_ch.last_of_run}, {7'd0, want.last});
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
rtl/core/tbple_pkg.sv
rtl/core/tbple_if.sv
rtl/core/three_bit_pulse_long_encoder_top.sv
tb/tb_three_bit_pulse_long_encoder_top.sv
